### rtl/kwl_pkg.sv
package kwl_pkg;

  localparam int PositionBits = 16;
  localparam int KeywordChars = 8;
  localparam int WindowBits   = KeywordChars * 8;
  localparam int KindBits     = 5;
  localparam int FieldBits    = 16;
  localparam int MaxResults   = 3;
  localparam int CountBits    = $clog2(MaxResults + 1);
  localparam int KeywordCount = 12;
  localparam int KwLenBits    = $clog2(KeywordChars + 1);
  localparam int QueueDepth   = 2;

  localparam logic [KindBits-1:0] KindIdent  = 5'd0;
  localparam logic [KindBits-1:0] KindNumber = 5'd1;
  localparam logic [KindBits-1:0] KindString = 5'd2;
  localparam logic [KindBits-1:0] KindHash   = 5'd3;
  localparam logic [KindBits-1:0] KindKey0   = 5'd4;
  localparam logic [KindBits-1:0] KindEnd    = 5'd16;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSlash = 8'h2F;

  // Keywords are packed with the first character in the highest used byte, right-aligned.
  // "native" is the spelling of the extern keyword.
  localparam logic [WindowBits-1:0] KwText [KeywordCount] = '{
    "macro", "using", "function", "end", "native", "while",
    "else", "do", "done", "if", "fi", "return"
  };
  localparam logic [KwLenBits-1:0] KwLen [KeywordCount] = '{
    4'd5, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd4, 4'd2, 4'd4, 4'd2, 4'd2, 4'd6
  };

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] length;
  } token_t;

  // All tokens caused by one input character.
  typedef struct packed {
    token_t [MaxResults-1:0] tok;
    logic [CountBits-1:0]    count;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

### rtl/kwl_in_if.sv
interface kwl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

### rtl/kwl_out_if.sv
interface kwl_out_if;
  logic                          valid;
  logic                          ready;
  logic [kwl_pkg::KindBits-1:0]  token_kind;
  logic [kwl_pkg::FieldBits-1:0] token_start;
  logic [kwl_pkg::FieldBits-1:0] token_length;
  logic                          last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input last_of_run, output ready);
endinterface

### rtl/keyword_token_lexer_core.sv
// Byte-serial lexer: one source character per cycle in while the queue is not full,
// tokens out as kind, start, length. A token passes the queue and the output register;
// a character that yields several tokens holds the output until all have left, and the
// two-entry queue between classifier and output absorbs the burst.
// Reset is asynchronous and active low; it clears the scan state and empties the queue.
module keyword_token_lexer_core #(
  parameter int POSITION_BITS = kwl_pkg::PositionBits
) (
  input logic       clk_i,
  input logic       rst_ni,
  kwl_in_if.sink    char_i,
  kwl_out_if.source token_o
);

  kwl_pkg::queue_status_t status;
  kwl_pkg::bundle_t       push_bundle;
  kwl_pkg::bundle_t       head_bundle;
  logic                   push;
  logic                   pop;

  kwl_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .status_i (status),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  kwl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .pop_i    (pop),
    .bundle_o (head_bundle),
    .status_o (status)
  );

  kwl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .bundle_i (head_bundle),
    .pop_o    (pop),
    .token_o  (token_o)
  );

endmodule

### rtl/kwl_front.sv
module kwl_front #(
  parameter int POSITION_BITS = kwl_pkg::PositionBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  kwl_in_if.sink                 char_i,
  input  kwl_pkg::queue_status_t status_i,
  output logic                   push_o,
  output kwl_pkg::bundle_t       bundle_o
);

  localparam int Pb = POSITION_BITS;
  localparam int Wb = kwl_pkg::WindowBits;

  typedef enum logic [1:0] {ModeIdle, ModeWord, ModeNumber, ModeString} mode_e;

  mode_e           mode_q, mode_d;
  logic [Wb-1:0]   win_q, win_d;
  logic [Pb-1:0]   len_q, len_d;
  logic [Pb-1:0]   beg_q, beg_d;
  logic [Pb-1:0]   pos_q, pos_d;
  logic            slash_q, slash_d;
  logic            cmt_q, cmt_d;
  kwl_pkg::bundle_t bundle;
  logic            acc;

  function automatic logic [Pb-1:0] sat_inc(input logic [Pb-1:0] v);
    return (&v) ? v : v + Pb'(1);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
           c == "x" || c == "X" || c == "o" || c == "O";
  endfunction

  function automatic logic [kwl_pkg::KindBits-1:0] word_kind(input logic [Wb-1:0] w,
                                                             input logic [Pb-1:0] l);
    logic [kwl_pkg::KindBits-1:0] k;
    k = kwl_pkg::KindIdent;
    if (l <= Pb'(kwl_pkg::KeywordChars)) begin
      for (int i = 0; i < kwl_pkg::KeywordCount; i++) begin
        if (w == kwl_pkg::KwText[i] && l == Pb'(kwl_pkg::KwLen[i])) begin
          k = kwl_pkg::KindKey0 + kwl_pkg::KindBits'(i);
        end
      end
    end
    return k;
  endfunction

  function automatic kwl_pkg::bundle_t push(input kwl_pkg::bundle_t b,
                                            input logic [kwl_pkg::KindBits-1:0] kind,
                                            input logic [Pb-1:0] start,
                                            input logic [Pb-1:0] len);
    kwl_pkg::bundle_t r;
    r = b;
    if (b.count != kwl_pkg::CountBits'(kwl_pkg::MaxResults)) begin
      r.tok[b.count].kind   = kind;
      r.tok[b.count].start  = kwl_pkg::FieldBits'(start);
      r.tok[b.count].length = kwl_pkg::FieldBits'(len);
      r.count               = b.count + kwl_pkg::CountBits'(1);
    end
    return r;
  endfunction

  function automatic kwl_pkg::bundle_t close_open(input kwl_pkg::bundle_t b, input mode_e m,
                                                  input logic [Wb-1:0] w,
                                                  input logic [Pb-1:0] start,
                                                  input logic [Pb-1:0] len);
    kwl_pkg::bundle_t r;
    r = b;
    unique case (m)
      ModeWord:   r = push(b, word_kind(w, len), start, len);
      ModeNumber: r = push(b, kwl_pkg::KindNumber, start, len);
      ModeString: r = push(b, kwl_pkg::KindString, start, len);
      ModeIdle:   r = b;
    endcase
    return r;
  endfunction

  assign char_i.ready = !status_i.full;
  assign acc          = char_i.valid && char_i.ready;

  always_comb begin
    logic [7:0] c;
    logic       handle;
    logic       restart;
    c       = char_i.char_byte;
    mode_d  = mode_q;
    win_d   = win_q;
    len_d   = len_q;
    beg_d   = beg_q;
    pos_d   = pos_q;
    slash_d = slash_q;
    cmt_d   = cmt_q;
    bundle  = '0;
    handle  = 1'b0;
    restart = 1'b0;

    // A held slash is settled by the character after it.
    if (cmt_q) begin
      if (c == kwl_pkg::ChLf) begin
        cmt_d  = 1'b0;
        handle = 1'b1;
      end
    end else if (slash_q) begin
      slash_d = 1'b0;
      if (c == kwl_pkg::ChSlash) begin
        cmt_d = 1'b1;
      end else begin
        if (mode_q == ModeString) begin
          len_d = sat_inc(len_d);
        end
        handle = 1'b1;
      end
    end else begin
      handle = 1'b1;
    end

    if (handle) begin
      if (c == kwl_pkg::ChSlash) begin
        slash_d = 1'b1;
        if (mode_d == ModeWord || mode_d == ModeNumber) begin
          bundle = close_open(bundle, mode_d, win_d, beg_d, len_d);
          mode_d = ModeIdle;
        end
      end else if (mode_d == ModeString) begin
        if (c == kwl_pkg::ChQuote || c == kwl_pkg::ChLf || c == kwl_pkg::ChCr ||
            c == kwl_pkg::ChNul) begin
          bundle = close_open(bundle, mode_d, win_d, beg_d, len_d);
          mode_d = ModeIdle;
        end else begin
          len_d = sat_inc(len_d);
        end
      end else begin
        restart = 1'b1;
        if (mode_d == ModeWord) begin
          if (is_alpha(c) || is_digit(c)) begin
            win_d   = {win_d[Wb-9:0], c};
            len_d   = sat_inc(len_d);
            restart = 1'b0;
          end else begin
            bundle = close_open(bundle, mode_d, win_d, beg_d, len_d);
            mode_d = ModeIdle;
          end
        end else if (mode_d == ModeNumber) begin
          if (is_num(c)) begin
            len_d   = sat_inc(len_d);
            restart = 1'b0;
          end else begin
            bundle = close_open(bundle, mode_d, win_d, beg_d, len_d);
            mode_d = ModeIdle;
          end
        end
        // The character that ended a word or number may itself open a token.
        if (restart) begin
          if (is_alpha(c)) begin
            mode_d = ModeWord;
            beg_d  = pos_q;
            len_d  = Pb'(1);
            win_d  = Wb'(c);
          end else if (is_digit(c)) begin
            mode_d = ModeNumber;
            beg_d  = pos_q;
            len_d  = Pb'(1);
          end else if (c == kwl_pkg::ChQuote) begin
            mode_d = ModeString;
            beg_d  = sat_inc(pos_q);
            len_d  = '0;
          end else if (c == kwl_pkg::ChHash) begin
            bundle = push(bundle, kwl_pkg::KindHash, pos_q, Pb'(1));
          end
        end
      end
    end

    pos_d = sat_inc(pos_q);

    if (char_i.end_of_source) begin
      if (slash_d && mode_d == ModeString) begin
        len_d = sat_inc(len_d);
      end
      bundle  = close_open(bundle, mode_d, win_d, beg_d, len_d);
      bundle  = push(bundle, kwl_pkg::KindEnd, pos_d, '0);
      mode_d  = ModeIdle;
      win_d   = '0;
      len_d   = '0;
      beg_d   = '0;
      pos_d   = '0;
      slash_d = 1'b0;
      cmt_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      win_q   <= '0;
      len_q   <= '0;
      beg_q   <= '0;
      pos_q   <= '0;
      slash_q <= 1'b0;
      cmt_q   <= 1'b0;
    end else if (acc) begin
      mode_q  <= mode_d;
      win_q   <= win_d;
      len_q   <= len_d;
      beg_q   <= beg_d;
      pos_q   <= pos_d;
      slash_q <= slash_d;
      cmt_q   <= cmt_d;
    end
  end

  assign push_o   = acc && (bundle.count != '0);
  assign bundle_o = bundle;

  a_no_slash_in_comment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmt_q && slash_q))
    else $error("held slash and comment state set together");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && char_i.end_of_source |=> pos_q == '0 && mode_q == ModeIdle && !cmt_q)
    else $error("state not cleared after end of source");

  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && char_i.end_of_source |-> push_o)
    else $error("end of source produced no transaction");

endmodule

### rtl/kwl_queue.sv
module kwl_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  kwl_pkg::bundle_t       bundle_i,
  input  logic                   pop_i,
  output kwl_pkg::bundle_t       bundle_o,
  output kwl_pkg::queue_status_t status_o
);

  localparam int Depth   = kwl_pkg::QueueDepth;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  kwl_pkg::bundle_t   entries_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign status_o.valid = count_q != '0;
  assign status_o.full  = count_q == CntBits'(Depth);
  assign bundle_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.valid)
    else $error("queue read while empty");

  a_pushed_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> status_o.valid)
    else $error("queue empty after a write");

endmodule

### rtl/kwl_back.sv
module kwl_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kwl_pkg::queue_status_t status_i,
  input  kwl_pkg::bundle_t       bundle_i,
  output logic                   pop_o,
  kwl_out_if.source              token_o
);

  kwl_pkg::bundle_t               cur_q;
  logic                           cur_valid_q;
  logic [kwl_pkg::CountBits-1:0]  idx_q;
  logic                           last_tok;
  logic                           advance;
  kwl_pkg::token_t                tok;

  assign tok      = cur_q.tok[idx_q];
  assign last_tok = idx_q == (cur_q.count - kwl_pkg::CountBits'(1));
  assign advance  = cur_valid_q && token_o.ready;
  // A new bundle is taken as soon as the last token of the current one leaves.
  assign pop_o    = status_i.valid && (!cur_valid_q || (advance && last_tok));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (advance) begin
      if (last_tok) begin
        cur_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + kwl_pkg::CountBits'(1);
      end
    end
  end

  assign token_o.valid        = cur_valid_q;
  assign token_o.token_kind   = tok.kind;
  assign token_o.token_start  = tok.start;
  assign token_o.token_length = tok.length;
  assign token_o.last_of_run  = last_tok;

endmodule
